// ===== rtl/rms_pkg.sv =====
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types, codes and helper functions of the robot mode sequencer.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int TICK_WIDTH = 16;
    localparam int TO_WIDTH   = 16;
    localparam int CMP_WIDTH  = (TICK_WIDTH > TO_WIDTH) ? TICK_WIDTH : TO_WIDTH;
    localparam int NUM_REGS   = 5;
    localparam int ADDR_WIDTH = 5;

    localparam logic [TO_WIDTH-1:0] TIMEOUT_RESET = TO_WIDTH'(100);

    localparam logic [2:0] REG_IDLE_TO     = 3'd0;
    localparam logic [2:0] REG_SITTING_TO  = 3'd1;
    localparam logic [2:0] REG_BIAS_TO     = 3'd2;
    localparam logic [2:0] REG_PREPOS_TO   = 3'd3;
    localparam logic [2:0] REG_STANDING_TO = 3'd4;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_DRIVE  = 3'd1;
    localparam logic [2:0] KIND_GAIT   = 3'd2;
    localparam logic [2:0] KIND_TURRET = 3'd3;
    localparam logic [2:0] KIND_SERVO  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_BIAS     = 3'd1,
        ST_PREPOS   = 3'd2,
        ST_STANDING = 3'd3,
        ST_MANUAL   = 3'd4,
        ST_DRIVE    = 3'd5,
        ST_SITTING  = 3'd6,
        ST_FAULT    = 3'd7
    } op_state_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_BIAS    = 3'd1,
        ACT_PREPOS  = 3'd2,
        ACT_STANDUP = 3'd3,
        ACT_SIT     = 3'd4,
        ACT_FREE    = 3'd5,
        ACT_FORWARD = 3'd6
    } action_t;

    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [TO_WIDTH-1:0]   timeout_t;

    typedef struct packed {
        timeout_t idle_to;
        timeout_t sitting_to;
        timeout_t bias_to;
        timeout_t prepos_to;
        timeout_t standing_to;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       moving;
        logic       servo_error;
        logic       cycles_done;
        logic       legs_in_stance;
    } item_t;

    typedef struct packed {
        op_state_t cur;
        tick_t     cmd_age;
        tick_t     phase_age;
        logic      active;
        logic      drive_moving;
        logic      manual_moving;
    } seq_state_t;

    typedef struct packed {
        op_state_t  op_state;
        action_t    action;
        logic       gait_active;
        logic       phase_restart;
    } result_t;

    typedef struct packed {
        logic active;
        logic phase_restart;
    } gait_t;

    function automatic tick_t sat_inc(input tick_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic expired(input tick_t age, input timeout_t limit);
        return CMP_WIDTH'(age) > CMP_WIDTH'(limit);
    endfunction

    function automatic gait_t gait_update(input logic want, input logic active,
                                          input logic cyc, input logic stance);
        gait_t g;
        g.active        = active;
        g.phase_restart = 1'b0;
        if (want && !active)
        begin
            g.active        = 1'b1;
            g.phase_restart = 1'b1;
        end
        else if (active && !want && cyc && stance)
        begin
            g.active = 1'b0;
        end
        return g;
    endfunction

endpackage

// ===== rtl/robot_mode_sequencer_core.sv =====
// Pipeline: an accepted transaction passes the input register, then the
// result register. Throughput: one transaction per cycle without a stall;
// the whole step is one pass of logic.
// Reset: rst_n clears the pipeline, puts the sequencer in idle with both tick
// counters and all flags cleared, and loads 100 into every timeout register.
// ----------------------------------------------------------------------------
// robot_mode_sequencer_core
// Top level: input register, sequencer state, result register and config.
// ----------------------------------------------------------------------------
module robot_mode_sequencer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     mode,
    input  logic                           moving,
    input  logic                           servo_error,
    input  logic                           cycles_done,
    input  logic                           legs_in_stance,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     operating_state,
    output logic [2:0]                     action,
    output logic                           gait_active,
    output logic                           phase_restart,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rms_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import rms_pkg::*;

    cfg_t       cfg;
    item_t      item_reg;
    logic       item_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       res_valid_reg;
    logic       res_free;
    logic       advance;
    logic       in_take;

    assign pready   = 1'b1;
    assign res_free = !res_valid_reg || !out_stall;
    assign advance  = item_valid_reg && res_free;
    assign in_stall = item_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    rms_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rms_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind           <= mode;
            item_reg.moving         <= moving;
            item_reg.servo_error    <= servo_error;
            item_reg.cycles_done    <= cycles_done;
            item_reg.legs_in_stance <= legs_in_stance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cur           <= ST_IDLE;
            state_reg.cmd_age       <= '0;
            state_reg.phase_age     <= '0;
            state_reg.active        <= 1'b0;
            state_reg.drive_moving  <= 1'b0;
            state_reg.manual_moving <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = res_valid_reg;
    assign operating_state = res_reg.op_state;
    assign action          = res_reg.action;
    assign gait_active     = res_reg.gait_active;
    assign phase_restart   = res_reg.phase_restart;

endmodule

// ===== rtl/rms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rms_cfg_regs
// Timeout register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module rms_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rms_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output rms_pkg::cfg_t                  cfg
);
    import rms_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_to     <= TIMEOUT_RESET;
            cfg_reg.sitting_to  <= TIMEOUT_RESET;
            cfg_reg.bias_to     <= TIMEOUT_RESET;
            cfg_reg.prepos_to   <= TIMEOUT_RESET;
            cfg_reg.standing_to <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_IDLE_TO:     cfg_reg.idle_to     <= pwdata[TO_WIDTH-1:0];
                REG_SITTING_TO:  cfg_reg.sitting_to  <= pwdata[TO_WIDTH-1:0];
                REG_BIAS_TO:     cfg_reg.bias_to     <= pwdata[TO_WIDTH-1:0];
                REG_PREPOS_TO:   cfg_reg.prepos_to   <= pwdata[TO_WIDTH-1:0];
                REG_STANDING_TO: cfg_reg.standing_to <= pwdata[TO_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IDLE_TO:     prdata = 32'(cfg_reg.idle_to);
            REG_SITTING_TO:  prdata = 32'(cfg_reg.sitting_to);
            REG_BIAS_TO:     prdata = 32'(cfg_reg.bias_to);
            REG_PREPOS_TO:   prdata = 32'(cfg_reg.prepos_to);
            REG_STANDING_TO: prdata = 32'(cfg_reg.standing_to);
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/rms_step.sv =====
// ----------------------------------------------------------------------------
// rms_step
// Next-state and result logic for one transaction of the mode sequencer.
// ----------------------------------------------------------------------------
module rms_step (
    input  rms_pkg::cfg_t       cfg,
    input  rms_pkg::seq_state_t cur,
    input  rms_pkg::item_t      item,
    output rms_pkg::seq_state_t nxt,
    output rms_pkg::result_t    res
);
    import rms_pkg::*;

    seq_state_t n;
    action_t    act;
    logic       rph;
    gait_t      g;
    op_state_t  target;

    always_comb
    begin
        n      = cur;
        act    = ACT_NONE;
        rph    = 1'b0;
        g      = '0;
        target = (item.kind == KIND_DRIVE) ? ST_DRIVE : ST_MANUAL;

        case (item.kind) inside
            KIND_TICK:
            begin
                n.cmd_age   = sat_inc(cur.cmd_age);
                n.phase_age = sat_inc(cur.phase_age);
                if (cur.cur != ST_IDLE && expired(n.cmd_age, cfg.idle_to))
                begin
                    unique case (cur.cur) inside
                        ST_BIAS:
                        begin
                            n.cur = ST_IDLE;
                        end
                        ST_PREPOS, ST_STANDING, ST_MANUAL, ST_DRIVE:
                        begin
                            n.cur       = ST_SITTING;
                            n.phase_age = '0;
                            act         = ACT_SIT;
                        end
                        ST_SITTING:
                        begin
                            if (expired(n.phase_age, cfg.sitting_to))
                            begin
                                n.cur = ST_IDLE;
                                act   = ACT_FREE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (n.cur == ST_MANUAL)
                begin
                    g        = gait_update(cur.manual_moving, cur.active,
                                           item.cycles_done, item.legs_in_stance);
                    n.active = g.active;
                    rph      = g.phase_restart;
                    act      = ACT_FORWARD;
                end
                else if (n.cur == ST_DRIVE)
                begin
                    g        = gait_update(cur.drive_moving, cur.active,
                                           item.cycles_done, item.legs_in_stance);
                    n.active = g.active;
                    rph      = g.phase_restart;
                    act      = ACT_FORWARD;
                end
                else if (n.cur == ST_FAULT)
                begin
                    act = ACT_FREE;
                end
            end
            KIND_DRIVE, KIND_GAIT, KIND_TURRET:
            begin
                n.cmd_age = '0;
                if (item.kind == KIND_DRIVE)
                begin
                    n.drive_moving = item.moving;
                end
                unique case (cur.cur)
                    ST_IDLE:
                    begin
                        n.cur       = ST_BIAS;
                        n.phase_age = '0;
                        act         = ACT_BIAS;
                    end
                    ST_BIAS:
                    begin
                        if (expired(cur.phase_age, cfg.bias_to))
                        begin
                            n.cur       = ST_PREPOS;
                            n.phase_age = '0;
                            act         = ACT_PREPOS;
                        end
                    end
                    ST_PREPOS:
                    begin
                        if (expired(cur.phase_age, cfg.prepos_to))
                        begin
                            n.cur       = ST_STANDING;
                            n.phase_age = '0;
                            act         = ACT_STANDUP;
                        end
                    end
                    ST_STANDING:
                    begin
                        if (expired(cur.phase_age, cfg.standing_to))
                        begin
                            n.cur = target;
                        end
                    end
                    ST_MANUAL, ST_DRIVE:
                    begin
                        n.cur = target;
                    end
                    default:
                    begin
                    end
                endcase
                if (item.kind == KIND_GAIT)
                begin
                    n.manual_moving = item.moving;
                end
                if (n.cur == target)
                begin
                    act = ACT_FORWARD;
                    if (item.kind == KIND_DRIVE)
                    begin
                        g        = gait_update(n.drive_moving, cur.active,
                                               item.cycles_done, item.legs_in_stance);
                        n.active = g.active;
                        rph      = g.phase_restart;
                    end
                end
            end
            KIND_SERVO:
            begin
                if (item.servo_error)
                begin
                    n.cur = ST_FAULT;
                end
            end
            default:
            begin
            end
        endcase

        nxt               = n;
        res.op_state      = n.cur;
        res.action        = act;
        res.gait_active   = n.active;
        res.phase_restart = rph;
    end

endmodule

// ===== rtl/rms_checker.sv =====
// ----------------------------------------------------------------------------
// rms_checker
// Port-level assertions for the mode sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rms_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] operating_state,
    input logic [2:0] action,
    input logic       gait_active,
    input logic       phase_restart
);
    import rms_pkg::*;

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(operating_state)
            && $stable(action) && $stable(gait_active) && $stable(phase_restart))
        else $error("stalled result changed");

    // A phase reset is only requested while the gait is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_restart |-> gait_active && action == ACT_FORWARD)
        else $error("phase reset without active gait");

    // Commands are forwarded only in manual or drive.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_FORWARD |->
            operating_state == ST_MANUAL || operating_state == ST_DRIVE)
        else $error("forward command outside an active mode");

    // Fault is left only through reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && operating_state == ST_FAULT ##1 out_valid
            |-> operating_state == ST_FAULT)
        else $error("left fault without reset");

endmodule

bind robot_mode_sequencer_core rms_checker u_rms_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the robot mode sequencer core. A behavioral copy of
// the sequencer predicts one result per accepted transaction. Directed tests
// walk the mode ladder, the timeout fall-back, all-ones timeouts and fault.
// Random phases with fresh timeouts follow, with random gaps on both sides
// and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    import rms_pkg::*;

    localparam int         CYCLE_LIMIT       = 1_500_000;
    localparam int         RANDOM_PHASES     = 10;
    localparam int         ITEMS_PER_PHASE   = 100;
    localparam int         LONG_RUN_TICKS    = 200;
    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [2:0]            mode;
    logic                  moving;
    logic                  servo_error;
    logic                  cycles_done;
    logic                  legs_in_stance;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            operating_state;
    logic [2:0]            action;
    logic                  gait_active;
    logic                  phase_restart;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    op_state_t seq_st;
    tick_t     cmd_age;
    tick_t     phase_age;
    logic      lift_on;
    logic      drive_mov;
    logic      manual_mov;
    timeout_t  cfg_to [NUM_REGS];

    result_t   outcome_q [$];
    int        n_sent;
    int        n_checked;
    int        n_errors;
    int        cycle_count;
    int        hold_left;
    int        stall_left;
    bit        quiet;

    robot_mode_sequencer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .moving          (moving),
        .servo_error     (servo_error),
        .cycles_done     (cycles_done),
        .legs_in_stance  (legs_in_stance),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .operating_state (operating_state),
        .action          (action),
        .gait_active     (gait_active),
        .phase_restart   (phase_restart),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("robot_mode_sequencer_core verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic update_lift(input logic want, input logic cyc, input logic stance);
        if (want && !lift_on)
        begin
            lift_on = 1'b1;
            return 1'b1;
        end
        if (lift_on && !want && cyc && stance)
            lift_on = 1'b0;
        return 1'b0;
    endfunction

    function automatic result_t advance_sequencer(input item_t it);
        result_t   r;
        op_state_t goal;
        action_t   act;
        logic      rise;
        act  = ACT_NONE;
        rise = 1'b0;
        case (it.kind)
            KIND_TICK:
            begin
                if (cmd_age != '1)
                    cmd_age = cmd_age + 1'b1;
                if (phase_age != '1)
                    phase_age = phase_age + 1'b1;
                if (seq_st != ST_IDLE && cmd_age > cfg_to[REG_IDLE_TO])
                begin
                    case (seq_st)
                        ST_BIAS:
                            seq_st = ST_IDLE;
                        ST_PREPOS, ST_STANDING, ST_MANUAL, ST_DRIVE:
                        begin
                            seq_st    = ST_SITTING;
                            phase_age = '0;
                            act       = ACT_SIT;
                        end
                        ST_SITTING:
                        begin
                            if (phase_age > cfg_to[REG_SITTING_TO])
                            begin
                                seq_st = ST_IDLE;
                                act    = ACT_FREE;
                            end
                        end
                        default:
                            ;
                    endcase
                end
                if (seq_st == ST_MANUAL)
                begin
                    rise = update_lift(manual_mov, it.cycles_done, it.legs_in_stance);
                    act  = ACT_FORWARD;
                end
                else if (seq_st == ST_DRIVE)
                begin
                    rise = update_lift(drive_mov, it.cycles_done, it.legs_in_stance);
                    act  = ACT_FORWARD;
                end
                else if (seq_st == ST_FAULT)
                begin
                    act = ACT_FREE;
                end
            end
            KIND_DRIVE, KIND_GAIT, KIND_TURRET:
            begin
                goal    = (it.kind == KIND_DRIVE) ? ST_DRIVE : ST_MANUAL;
                cmd_age = '0;
                if (it.kind == KIND_DRIVE)
                    drive_mov = it.moving;
                case (seq_st)
                    ST_IDLE:
                    begin
                        seq_st    = ST_BIAS;
                        phase_age = '0;
                        act       = ACT_BIAS;
                    end
                    ST_BIAS:
                    begin
                        if (phase_age > cfg_to[REG_BIAS_TO])
                        begin
                            seq_st    = ST_PREPOS;
                            phase_age = '0;
                            act       = ACT_PREPOS;
                        end
                    end
                    ST_PREPOS:
                    begin
                        if (phase_age > cfg_to[REG_PREPOS_TO])
                        begin
                            seq_st    = ST_STANDING;
                            phase_age = '0;
                            act       = ACT_STANDUP;
                        end
                    end
                    ST_STANDING:
                    begin
                        if (phase_age > cfg_to[REG_STANDING_TO])
                            seq_st = goal;
                    end
                    ST_MANUAL, ST_DRIVE:
                        seq_st = goal;
                    default:
                        ;
                endcase
                if (it.kind == KIND_GAIT)
                    manual_mov = it.moving;
                if (seq_st == goal)
                begin
                    act = ACT_FORWARD;
                    if (it.kind == KIND_DRIVE)
                        rise = update_lift(drive_mov, it.cycles_done, it.legs_in_stance);
                end
            end
            KIND_SERVO:
            begin
                if (it.servo_error)
                    seq_st = ST_FAULT;
            end
            default:
                ;
        endcase
        r.op_state      = seq_st;
        r.action        = act;
        r.gait_active   = lift_on;
        r.phase_restart = rise;
        return r;
    endfunction

    task automatic check_field(input string what, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0t mismatch %s: expected %0d, actual %0d",
                         $time, what, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        item_t   seen;
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                n_errors++;
                $display("%0t unexpected result: expected none, actual state %0d action %0d",
                         $time, operating_state, action);
            end
            else
            begin
                want = outcome_q.pop_front();
                n_checked++;
                check_field("operating_state", want.op_state, operating_state);
                check_field("action", want.action, action);
                check_field("gait_active", want.gait_active, gait_active);
                check_field("phase_restart", want.phase_restart, phase_restart);
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            seen = {mode, moving, servo_error, cycles_done, legs_in_stance};
            outcome_q.insert(outcome_q.size(), advance_sequencer(seen));
        end
    end

    initial
    begin
        out_stall  = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left = hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                out_stall  = 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_stall = 1'b0;
                if (!quiet && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    function automatic item_t make_item(input logic [2:0] kind, input logic mov,
                                        input logic serr, input logic cyc,
                                        input logic stance);
        item_t it;
        it.kind           = kind;
        it.moving         = mov;
        it.servo_error    = serr;
        it.cycles_done    = cyc;
        it.legs_in_stance = stance;
        return it;
    endfunction

    function automatic item_t draw_item(input int tick_pct);
        item_t it;
        int    r;
        r                 = $urandom_range(0, 99);
        it.moving         = 1'($urandom);
        it.servo_error    = 1'($urandom);
        it.cycles_done    = 1'($urandom);
        it.legs_in_stance = 1'($urandom);
        if (r < tick_pct)
        begin
            it.kind = KIND_TICK;
        end
        else if (r < 90)
        begin
            it.kind = 3'($urandom_range(KIND_DRIVE, KIND_TURRET));
        end
        else if (r < 95)
        begin
            it.kind        = KIND_SERVO;
            it.servo_error = 1'b0;
        end
        else
        begin
            it.kind = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        end
        return it;
    endfunction

    function automatic timeout_t draw_timeout();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return timeout_t'($urandom);
        return timeout_t'($urandom_range(1, 12));
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 30)
            gap = pick_gap();
        repeat (gap) @(negedge clk);
        in_valid       = 1'b1;
        mode           = it.kind;
        moving         = it.moving;
        servo_error    = it.servo_error;
        cycles_done    = it.cycles_done;
        legs_in_stance = it.legs_in_stance;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [2:0] idx, input timeout_t val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_WIDTH'({idx, 2'b00});
        pwdata  = 32'(val);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        cfg_to[idx] = val;
        penable     = 1'b0;
        pwrite      = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        check_field("register readback", val, prdata[15:0]);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_timeouts(input timeout_t idle_v, input timeout_t sit_v,
                                input timeout_t bias_v, input timeout_t prep_v,
                                input timeout_t stand_v);
        wait_idle();
        write_timeout(REG_IDLE_TO, idle_v);
        write_timeout(REG_SITTING_TO, sit_v);
        write_timeout(REG_BIAS_TO, bias_v);
        write_timeout(REG_PREPOS_TO, prep_v);
        write_timeout(REG_STANDING_TO, stand_v);
    endtask

    // Climb from idle to manual and drive; exercises the gait flag rise and fall.
    task automatic test_mode_ladder();
        set_timeouts(16'd1000, 16'd0, 16'd1, 16'd0, 16'd0);
        send_item(make_item(KIND_TICK, 1'b1, 1'b1, 1'b0, 1'b0));
        send_item(make_item(KIND_GAIT, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TURRET, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TURRET, 1'b0, 1'b1, 1'b0, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_DRIVE, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TURRET, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_GAIT, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_item(KIND_GAIT, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b1, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_item(KIND_DRIVE, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_DRIVE, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_item(KIND_SERVO, 1'b1, 1'b0, 1'b1, 1'b1));
        send_item(make_item(KIND_UNUSED_LAST, 1'b1, 1'b1, 1'b1, 1'b1));
        send_item(make_item(KIND_TURRET, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    // Lapse of commands drops manual to sitting, then frees the servos.
    task automatic test_idle_fallback();
        set_timeouts(16'd2, 16'd1, 16'd0, 16'd0, 16'd0);
        send_item(make_item(KIND_GAIT, 1'b0, 1'b0, 1'b0, 1'b0));
        repeat (3) send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_item(KIND_TURRET, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (3) send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_DRIVE, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (3) send_item(make_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    // A long run of ticks under all-ones idle, sitting and prepos timeouts keeps the sequencer in place.
    task automatic test_long_timeouts();
        set_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'd0);
        quiet = 1'b1;
        send_item(make_item(KIND_GAIT, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (LONG_RUN_TICKS)
            send_item(make_item(KIND_TICK, 1'($urandom), 1'($urandom),
                                1'($urandom), 1'($urandom)));
        send_item(make_item(KIND_TURRET, 1'b0, 1'b0, 1'b0, 1'b0));
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        set_timeouts(16'd6, 16'd3, 16'd2, 16'd2, 16'd2);
        hold_left = 150;
        quiet     = 1'b1;
        repeat (30) send_item(draw_item(50));
        while (hold_left != 0)
            @(negedge clk);
        quiet = 1'b0;
    endtask

    task automatic test_random_phases();
        int tick_pct;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_timeouts(draw_timeout(), draw_timeout(), draw_timeout(),
                         draw_timeout(), draw_timeout());
            quiet    = ($urandom_range(0, 3) == 0);
            tick_pct = $urandom_range(30, 70);
            repeat (ITEMS_PER_PHASE) send_item(draw_item(tick_pct));
        end
        quiet = 1'b0;
    endtask

    // Fault is sticky until reset, so this runs last.
    task automatic test_servo_fault();
        set_timeouts(16'd4, 16'd2, 16'd1, 16'd1, 16'd1);
        send_item(make_item(KIND_SERVO, 1'b0, 1'b1, 1'b0, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b1, 1'b1));
        send_item(make_item(KIND_DRIVE, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_GAIT, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_SERVO, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = KIND_TICK;
        moving         = 1'b0;
        servo_error    = 1'b0;
        cycles_done    = 1'b0;
        legs_in_stance = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        quiet          = 1'b0;
        n_sent         = 0;
        n_checked      = 0;
        n_errors       = 0;
        seq_st         = ST_IDLE;
        cmd_age        = '0;
        phase_age      = '0;
        lift_on        = 1'b0;
        drive_mov      = 1'b0;
        manual_mov     = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
            cfg_to[i] = TIMEOUT_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_mode_ladder();
        test_idle_fallback();
        test_long_timeouts();
        test_backpressure();
        test_random_phases();
        test_servo_fault();

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Sent %0d transactions and checked %0d results over %0d random phases,",
                 n_sent, n_checked, RANDOM_PHASES);
        $display("plus mode ladder, fall-back, all-ones timeouts, output hold-off and fault.");
        if (n_errors == 0)
        begin
            $display("robot_mode_sequencer_core verification clean");
        end
        else
        begin
            $display("robot_mode_sequencer_core verification failed");
        end
        $finish;
    end

endmodule
